FILE: src/msht_pkg.sv
// ----------------------------------------------------------------------------
// msht_pkg: shared types and constants of the miss status holding table
// Holds the payload structs, request codes and table geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package msht_pkg;

  // Table geometry. TABLE_DEPTH must be a power of two: the slot is the low
  // bits of the line index.
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned MAX_WAITERS = 8;

  localparam int unsigned SLOT_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned HEAD_W    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned POS_W     = HEAD_W + 1;
  localparam int unsigned TAG_DEPTH = TABLE_DEPTH * MAX_WAITERS;
  localparam int unsigned TAG_AW    = $clog2(TAG_DEPTH);

  // Field widths.
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned USE_W  = 4;
  localparam int unsigned FREE_W = 12;

  localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

  localparam logic signed [FREE_W-1:0] FREE_MIN = {1'b1, {(FREE_W - 1){1'b0}}};
  localparam logic signed [FREE_W-1:0] FREE_MAX = {1'b0, {(FREE_W - 1){1'b1}}};

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned LIMIT_W    = 11;
  localparam int unsigned SUB_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LINE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_ENTRY_LIMIT = 2'd2;

  localparam logic [SHIFT_W-1:0] LOG2_LINE_SIZE_RST  = 4'd6;
  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST     = 11'd16;
  localparam logic [SUB_W-1:0]   SUB_ENTRY_LIMIT_RST = 4'd4;

  typedef enum logic [1:0] {
    REQ_QUERY  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_BLOCK  = 2'd2,
    REQ_RETIRE = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [ADDR_W-1:0] address;
    logic [TAG_W-1:0]  waiter_tag;
  } req_t;

  typedef struct packed {
    logic                     can_accept;
    logic                     can_issue;
    logic                     woke;
    logic [TAG_W-1:0]         wake_tag;
    logic                     misuse;
    logic signed [FREE_W-1:0] free_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: src/msht_ram.sv
// ----------------------------------------------------------------------------
// msht_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module msht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/miss_status_holding_table.sv
// ----------------------------------------------------------------------------
// miss_status_holding_table: miss status holding table for a cache
// Tracks outstanding misses per cache line slot, queues waiters behind busy
// slots and wakes them in order on retire.
// ----------------------------------------------------------------------------
// The slot RAM is read at the edge that accepts a request. The update stage
// then writes the slot back and loads the result into the output register,
// waiting for that register to be free. A retire that wakes a queued waiter
// parks its result instead and reads the waiter's tag from a second RAM whose
// address depends on the head just read; the result with the tag is loaded
// once the output register is free. The block handles one request at a time
// and takes the next one only after the previous one has left the update
// stage and, for a wake, the tag read. A result that waits in the output
// register does not block the next acceptance, but that next request holds
// in the update stage, or in the tag read after a wake, until the output
// register frees up. The slot RAM needs no clearing pass after reset: a valid
// flop per slot makes a never-written slot read as idle with its head at zero.
// Configuration is written through its own port, which is ready only while no
// request is in flight and takes priority over a request offered in the same
// cycle; a write of the entry limit also reloads the free entry count.
`default_nettype none

module miss_status_holding_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire msht_pkg::req_t                      in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output msht_pkg::rsp_t                           out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [msht_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [msht_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SLOT_W = msht_pkg::SLOT_W;
  localparam int unsigned HEAD_W = msht_pkg::HEAD_W;
  localparam int unsigned POS_W  = msht_pkg::POS_W;
  localparam int unsigned USE_W  = msht_pkg::USE_W;
  localparam int unsigned FREE_W = msht_pkg::FREE_W;
  localparam int unsigned TAG_AW = msht_pkg::TAG_AW;
  localparam int unsigned TAG_W  = msht_pkg::TAG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_TAG
  } state_e;

  // One slot RAM word: use count and the position of the oldest waiter.
  typedef struct packed {
    logic [USE_W-1:0]  use_cnt;
    logic [HEAD_W-1:0] head;
  } slot_t;

  state_e state_q;

  // Configuration registers.
  logic [msht_pkg::SHIFT_W-1:0] log2_line_size_q;
  logic [msht_pkg::SUB_W-1:0]   sub_entry_limit_q;
  logic signed [FREE_W-1:0]     free_q;

  // Request held while it is worked on.
  msht_pkg::req_type_e req_type_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [TAG_W-1:0]    waiter_tag_q;
  logic                slot_rd_vld_q;

  // A slot whose bit is clear has never been written and reads as idle.
  logic [msht_pkg::TABLE_DEPTH-1:0] slot_vld_q;

  // Result parked while the waiter's tag is read.
  msht_pkg::rsp_t pend_q;

  logic           out_valid_q;
  msht_pkg::rsp_t out_data_q;
  msht_pkg::rsp_t out_data_d;
  logic           out_load;

  // ---------------------------------------------------------------------------
  // Slot index of an incoming request.
  // ---------------------------------------------------------------------------
  logic [msht_pkg::ADDR_W-1:0] line_addr;
  logic [SLOT_W-1:0]           in_slot;
  logic                        in_fire;
  logic                        cfg_fire;

  assign line_addr   = in_data_i.address >> log2_line_size_q;
  assign in_slot     = line_addr[SLOT_W-1:0];
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Memories.
  // ---------------------------------------------------------------------------
  logic  slot_we;
  slot_t slot_wdata;
  slot_t slot_rdata;
  logic  tag_we;
  logic  tag_re;
  logic [TAG_AW-1:0] tag_waddr;
  logic [TAG_AW-1:0] tag_raddr;
  logic [TAG_W-1:0]  tag_rdata;

  msht_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(msht_pkg::TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_q),
    .wdata_i(slot_wdata),
    .re_i   (in_fire),
    .raddr_i(in_slot),
    .rdata_o(slot_rdata)
  );

  msht_ram #(
    .WIDTH(TAG_W),
    .DEPTH(msht_pkg::TAG_DEPTH)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(tag_waddr),
    .wdata_i(waiter_tag_q),
    .re_i   (tag_re),
    .raddr_i(tag_raddr),
    .rdata_o(tag_rdata)
  );

  // ---------------------------------------------------------------------------
  // Update stage: decide the operation on the slot just read.
  // ---------------------------------------------------------------------------
  logic [USE_W-1:0]         use_cur;
  logic [HEAD_W-1:0]        head_cur;
  logic [POS_W-1:0]         pos_sum;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         head_inc;
  logic [HEAD_W-1:0]        head_next;
  logic [USE_W-1:0]         use_new;
  logic [HEAD_W-1:0]        head_new;
  logic signed [FREE_W-1:0] free_new;
  logic                     misuse;
  logic                     woke;
  logic                     changes;
  logic                     out_free;
  logic                     commit;
  logic [TAG_AW-1:0]        slot_base;
  msht_pkg::rsp_t           rsp;

  assign use_cur  = slot_rd_vld_q ? slot_rdata.use_cnt : '0;
  assign head_cur = slot_rd_vld_q ? slot_rdata.head : '0;

  // Tail position of the circular queue; both terms stay below MAX_WAITERS
  // whenever it is used, so one conditional subtract wraps it.
  assign pos_sum = POS_W'(head_cur) + POS_W'(use_cur - USE_W'(1));
  assign pos     = (pos_sum >= POS_W'(msht_pkg::MAX_WAITERS)) ?
                   pos_sum - POS_W'(msht_pkg::MAX_WAITERS) : pos_sum;

  assign head_inc  = POS_W'(head_cur) + POS_W'(1);
  assign head_next = (head_inc == POS_W'(msht_pkg::MAX_WAITERS)) ?
                     '0 : head_inc[HEAD_W-1:0];

  always_comb begin
    use_new  = use_cur;
    head_new = head_cur;
    free_new = free_q;
    misuse   = 1'b0;
    woke     = 1'b0;
    changes  = 1'b0;
    case (req_type_q)
      msht_pkg::REQ_ADD: begin
        // The queue is full once use - 1 reaches MAX_WAITERS.
        if (use_cur == '0 ||
            {1'b0, use_cur} > (USE_W + 1)'(msht_pkg::MAX_WAITERS) ||
            use_cur == msht_pkg::USE_MAX || free_q == msht_pkg::FREE_MIN) begin
          misuse = 1'b1;
        end else begin
          use_new  = use_cur + USE_W'(1);
          free_new = free_q - FREE_W'(1);
          changes  = 1'b1;
        end
      end
      msht_pkg::REQ_BLOCK: begin
        if (use_cur != '0 || free_q == msht_pkg::FREE_MIN) begin
          misuse = 1'b1;
        end else begin
          use_new  = USE_W'(1);
          free_new = free_q - FREE_W'(1);
          changes  = 1'b1;
        end
      end
      msht_pkg::REQ_RETIRE: begin
        if (use_cur == '0 || free_q == msht_pkg::FREE_MAX) begin
          misuse = 1'b1;
        end else begin
          use_new  = use_cur - USE_W'(1);
          free_new = free_q + FREE_W'(1);
          changes  = 1'b1;
          if (use_cur != USE_W'(1)) begin
            woke     = 1'b1;
            head_new = head_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.can_accept = !free_q[FREE_W-1] && (free_q != '0) &&
                          (use_cur < sub_entry_limit_q);
  assign rsp.can_issue  = (use_cur == '0);
  assign rsp.woke       = woke;
  assign rsp.wake_tag   = '0;
  assign rsp.misuse     = misuse;
  assign rsp.free_count = free_new;

  // A result without a tag goes straight to the output register, so the
  // update waits for it to be free. A wake goes on to the tag read.
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (state_q == ST_SLOT) && (woke || out_free);
  assign out_load = (commit && !woke) || ((state_q == ST_TAG) && out_free);

  // A woken waiter's result is the parked one with the tag just read.
  always_comb begin
    out_data_d = rsp;
    if (state_q == ST_TAG) begin
      out_data_d          = pend_q;
      out_data_d.wake_tag = tag_rdata;
    end
  end

  assign slot_base  = TAG_AW'(slot_q) * TAG_AW'(msht_pkg::MAX_WAITERS);
  assign slot_we    = commit && changes;
  assign slot_wdata = '{use_cnt: use_new, head: head_new};
  assign tag_we     = slot_we && (req_type_q == msht_pkg::REQ_ADD);
  assign tag_waddr  = slot_base + TAG_AW'(pos[HEAD_W-1:0]);
  assign tag_re     = commit && woke;
  assign tag_raddr  = slot_base + TAG_AW'(head_cur);

  // ---------------------------------------------------------------------------
  // Control, configuration and output registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      log2_line_size_q  <= msht_pkg::LOG2_LINE_SIZE_RST;
      sub_entry_limit_q <= msht_pkg::SUB_ENTRY_LIMIT_RST;
      free_q            <= FREE_W'(msht_pkg::ENTRY_LIMIT_RST);
      slot_vld_q        <= '0;
      out_valid_q       <= 1'b0;
      out_data_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= out_data_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_SLOT;
          end
        end
        ST_SLOT: begin
          if (commit) begin
            free_q <= free_new;
            if (slot_we) begin
              slot_vld_q[slot_q] <= 1'b1;
            end
            if (woke) begin
              state_q <= ST_TAG;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_TAG: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // Writes land only while no request is in flight.
      if (cfg_fire) begin
        unique case (cfg_index_i)
          msht_pkg::CFG_LOG2_LINE_SIZE: begin
            log2_line_size_q <= cfg_data_i[msht_pkg::SHIFT_W-1:0];
          end
          msht_pkg::CFG_ENTRY_LIMIT: begin
            free_q <= FREE_W'(cfg_data_i[msht_pkg::LIMIT_W-1:0]);
          end
          msht_pkg::CFG_SUB_ENTRY_LIMIT: begin
            sub_entry_limit_q <= cfg_data_i[msht_pkg::SUB_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Request and parked result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q    <= in_data_i.req_type;
      slot_q        <= in_slot;
      waiter_tag_q  <= in_data_i.waiter_tag;
      slot_rd_vld_q <= slot_vld_q[in_slot];
    end
    if (tag_re) begin
      pend_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
